// ===== rtl/core/tsqt_pkg.sv =====
`default_nettype none
package tsqt_pkg;
   typedef enum logic [2:0] {
      OP_ACQUIRE = 3'd0, OP_RELEASE = 3'd1, OP_RELEASE_ALL = 3'd2, OP_ADD = 3'd3,
      OP_REMOVE = 3'd4, OP_SET_LIMIT = 3'd5, OP_RESET_STATS = 3'd6, OP_QUERY = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_LIMIT = 3'd1, ST_GLOBAL = 3'd2, ST_INVALID = 3'd3,
      ST_NOT_FOUND = 3'd4, ST_FULL = 3'd5
   } status_type;

   localparam int unsigned OP_BITS     = 3;
   localparam int unsigned TENANT_BITS = 6;
   localparam int unsigned FIELD_BITS  = 16;
   localparam int unsigned POOL_BITS   = 22;
   localparam int unsigned COUNT_BITS  = 7;
   localparam int unsigned CSR_IDX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_POOL_CAP      = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEFAULT_LIMIT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_TENANTS   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AUTO_CREATE   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRACK_STATS   = 3'd4;

   localparam logic [FIELD_BITS-1:0] RESET_DEFAULT_LIMIT = 16'd10;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pool_cap;
      logic [FIELD_BITS-1:0] default_limit;
      logic [COUNT_BITS-1:0] max_tenants;
      logic                  auto_create;
      logic                  track_stats;
   } cfg_type;

   typedef struct packed {
      logic [OP_BITS-1:0]     op;
      logic [TENANT_BITS-1:0] tenant;
      logic [FIELD_BITS-1:0]  slot_count;
      logic [FIELD_BITS-1:0]  new_limit;
      logic                   use_default;
      logic                   global_flag;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [FIELD_BITS-1:0] released_count;
      logic [FIELD_BITS-1:0] tenant_active;
      logic [FIELD_BITS-1:0] tenant_peak;
      logic [31:0]           tenant_acquires;
      logic [31:0]           tenant_releases;
      logic [31:0]           tenant_denied;
      logic [POOL_BITS-1:0]  pool_active;
      logic [POOL_BITS-1:0]  pool_peak;
      logic [COUNT_BITS-1:0] tenants_present;
      logic [31:0]           all_acquires;
      logic [31:0]           all_denied;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/core/tsqt_if.sv =====
`default_nettype none
interface tsqt_req_if import tsqt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tsqt_rsp_if import tsqt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tsqt_csr.sv =====
`default_nettype none
module tsqt_csr import tsqt_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data,
   output cfg_type                       cfg
);
   cfg_type cfg_ff, cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_POOL_CAP:      cfg_in.pool_cap      = csr_data;
            CSR_DEFAULT_LIMIT: cfg_in.default_limit = csr_data;
            CSR_MAX_TENANTS:   cfg_in.max_tenants   = csr_data[COUNT_BITS-1:0];
            CSR_AUTO_CREATE:   cfg_in.auto_create   = csr_data[0];
            CSR_TRACK_STATS:   cfg_in.track_stats   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pool_cap      <= '0;
         cfg_ff.default_limit <= RESET_DEFAULT_LIMIT;
         cfg_ff.max_tenants   <= '0;
         cfg_ff.auto_create   <= 1'b1;
         cfg_ff.track_stats   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// ===== rtl/core/tenant_slot_quota_table_core.sv =====
// Per-tenant concurrency quota table.
// req channel: one operation per transfer (op, tenant, slot_count, new_limit,
//   use_default, global_flag). rsp channel: one result per operation, with
//   status and a snapshot of the tenant and of the pool after the operation.
// csr port: write enable, register index and data; the user must write it
// only when idle, which the block itself does not enforce. The tenant entry
// of each operation is read from the table memory into a read register, then
// modified and written back in the modify stage, where the result is loaded
// into the output register. A new request is accepted only when no operation
// is in the modify stage and the output register is empty or its result is
// taken in the same cycle, so no request is taken before the last is written
// back, set by the single read-modify-write path through the table memory.
// Reset (synchronous) clears the present marks, pool counters and valid flags;
// table entries are written on creation and need no clearing pass.
// A stalled rsp holds its result and keeps req.ready low until it is taken.
`default_nettype none
module tenant_slot_quota_table_core import tsqt_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   tsqt_req_if.sink                      req,
   tsqt_rsp_if.source                    rsp,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);
   localparam int unsigned TENANTS = 64;

   typedef struct packed {
      logic [FIELD_BITS-1:0] limit;
      logic [FIELD_BITS-1:0] held;
      logic [FIELD_BITS-1:0] peak;
      logic [31:0]           acq;
      logic [31:0]           rel;
      logic [31:0]           den;
   } entry_type;

   cfg_type cfg;
   tsqt_csr u_csr (.clock, .reset, .csr_write, .csr_index, .csr_data, .cfg);

   entry_type mem [TENANTS];
   entry_type rd_ff;
   logic [TENANTS-1:0] present_ff, present_in;
   logic s1_ff, s1_in;
   req_type r_ff;
   logic [POOL_BITS-1:0] gheld_ff, gheld_in, gpeak_ff, gpeak_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [31:0] tacq_ff, tacq_in, tden_ff, tden_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;
   entry_type e, wr;
   logic wen;

   // accept only when nothing is in flight; output register must be free
   assign req.ready = !s1_ff && (!rv_ff || rsp.ready);
   assign s1_in = req.valid && req.ready;

   // table read
   always_ff @(posedge clock) begin
      if (s1_in) begin
         rd_ff <= mem[req.payload.tenant];
         r_ff  <= req.payload;
      end
      if (wen) mem[r_ff.tenant] <= wr;
   end

   // modify stage
   always_comb begin
      logic pres, glob_ex, lim_ex, deny, okacq, can_create;
      logic [COUNT_BITS-1:0] cap;
      logic [FIELD_BITS-1:0] cnt, freed;
      logic [POOL_BITS:0] gsum;
      logic [FIELD_BITS:0] tsum;
      status_type st;
      e = rd_ff; wr = rd_ff; wen = 1'b0;
      present_in = present_ff; gheld_in = gheld_ff; gpeak_in = gpeak_ff;
      total_in = total_ff; tacq_in = tacq_ff; tden_in = tden_ff;
      st = ST_OK; freed = '0; deny = 1'b0; okacq = 1'b0;
      pres = present_ff[r_ff.tenant];
      cap = (cfg.max_tenants == '0 || cfg.max_tenants > COUNT_BITS'(TENANTS))
            ? COUNT_BITS'(TENANTS) : cfg.max_tenants;
      can_create = total_ff < cap;
      cnt = r_ff.slot_count;
      gsum = {1'b0, gheld_ff} + (POOL_BITS+1)'(cnt);
      glob_ex = cfg.pool_cap != '0 && gsum > (POOL_BITS+1)'(cfg.pool_cap);
      if (!pres) e = '{limit: cfg.default_limit, default: '0};
      tsum = {1'b0, e.held} + {1'b0, cnt};
      lim_ex = tsum > {1'b0, e.limit};
      case (r_ff.op)
         OP_ACQUIRE: begin
            if (cnt == '0) st = ST_INVALID;
            else if (!pres && !(cfg.auto_create && can_create)) st = ST_NOT_FOUND;
            else begin
               wen = 1'b1;
               if (!pres) begin
                  present_in[r_ff.tenant] = 1'b1;
                  total_in = total_ff + 1'b1;
               end
               if (glob_ex) begin st = ST_GLOBAL; deny = 1'b1; end
               else if (lim_ex) begin st = ST_LIMIT; deny = 1'b1; end
               else okacq = 1'b1;
            end
            wr = e;
            if (okacq) begin
               wr.held = tsum[FIELD_BITS-1:0];
               if (tsum[FIELD_BITS-1:0] > e.peak) wr.peak = tsum[FIELD_BITS-1:0];
               gheld_in = gsum[POOL_BITS-1:0];
               if (gsum[POOL_BITS-1:0] > gpeak_ff) gpeak_in = gsum[POOL_BITS-1:0];
               if (cfg.track_stats) begin
                  wr.acq = e.acq + 1'b1;
                  tacq_in = tacq_ff + 1'b1;
               end
            end
            if (deny && cfg.track_stats) begin
               wr.den = e.den + 1'b1;
               tden_in = tden_ff + 1'b1;
            end
         end
         OP_RELEASE, OP_RELEASE_ALL: begin
            if (r_ff.op == OP_RELEASE && cnt == '0) st = ST_INVALID;
            else if (!pres) st = ST_NOT_FOUND;
            else begin
               freed = (r_ff.op == OP_RELEASE_ALL || cnt > e.held) ? e.held : cnt;
               if (freed != '0) begin
                  wen = 1'b1;
                  wr.held = e.held - freed;
                  gheld_in = (POOL_BITS'(freed) > gheld_ff) ? '0
                             : gheld_ff - POOL_BITS'(freed);
                  if (cfg.track_stats) wr.rel = e.rel + 1'b1;
               end
            end
         end
         OP_ADD: begin
            if (!pres) begin
               if (!can_create) st = ST_FULL;
               else begin
                  wen = 1'b1;
                  wr = '{limit: (r_ff.use_default ? cfg.default_limit : r_ff.new_limit),
                         default: '0};
                  present_in[r_ff.tenant] = 1'b1;
                  total_in = total_ff + 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (!pres) st = ST_NOT_FOUND;
            else begin
               freed = e.held;
               gheld_in = (POOL_BITS'(freed) > gheld_ff) ? '0
                          : gheld_ff - POOL_BITS'(freed);
               present_in[r_ff.tenant] = 1'b0;
               if (total_ff != '0) total_in = total_ff - 1'b1;
            end
         end
         OP_SET_LIMIT: begin
            if (!pres) st = ST_NOT_FOUND;
            else begin wen = 1'b1; wr.limit = r_ff.new_limit; end
         end
         OP_RESET_STATS: begin
            if (!pres) st = ST_NOT_FOUND;
            else begin
               wen = 1'b1;
               wr.peak = e.held; wr.acq = '0; wr.rel = '0; wr.den = '0;
            end
         end
         default: begin
            if (r_ff.global_flag) begin
               gpeak_in = gheld_ff; tacq_in = '0; tden_in = '0;
            end else if (cnt == '0) st = ST_INVALID;
            else if (pres) st = lim_ex ? ST_LIMIT : (glob_ex ? ST_GLOBAL : ST_OK);
            else if (!cfg.auto_create) st = ST_NOT_FOUND;
            else st = glob_ex ? ST_GLOBAL : ST_OK;
         end
      endcase
      if (!s1_ff) begin
         wen = 1'b0; present_in = present_ff; gheld_in = gheld_ff;
         gpeak_in = gpeak_ff; total_in = total_ff; tacq_in = tacq_ff;
         tden_in = tden_ff;
      end
      rsp_in.status = st;
      rsp_in.released_count = freed;
      if (present_in[r_ff.tenant]) begin
         rsp_in.tenant_active = wr.held;
         rsp_in.tenant_peak = wr.peak;
         rsp_in.tenant_acquires = wr.acq;
         rsp_in.tenant_releases = wr.rel;
         rsp_in.tenant_denied = wr.den;
      end else begin
         rsp_in.tenant_active = '0; rsp_in.tenant_peak = '0;
         rsp_in.tenant_acquires = '0; rsp_in.tenant_releases = '0;
         rsp_in.tenant_denied = '0;
      end
      rsp_in.pool_active = gheld_in;
      rsp_in.pool_peak = gpeak_in;
      rsp_in.tenants_present = total_in;
      rsp_in.all_acquires = tacq_in;
      rsp_in.all_denied = tden_in;
   end

   assign rv_in = s1_ff ? 1'b1 : (rv_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0; rv_ff <= 1'b0; present_ff <= '0;
         gheld_ff <= '0; gpeak_ff <= '0; total_ff <= '0;
         tacq_ff <= '0; tden_ff <= '0;
      end else begin
         s1_ff <= s1_in; rv_ff <= rv_in; present_ff <= present_in;
         gheld_ff <= gheld_in; gpeak_ff <= gpeak_in; total_ff <= total_in;
         tacq_ff <= tacq_in; tden_ff <= tden_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ff) rsp_ff <= rsp_in;
   end

   assign rsp.valid = rv_ff;
   assign rsp.payload = rsp_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_ff |-> (!rv_ff || $past(rsp.ready))) else $error("result overwritten");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      s1_ff |=> !s1_ff) else $error("two requests in flight");
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= COUNT_BITS'(TENANTS)) else $error("tenant count overflow");
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      COUNT_BITS'($countones(present_ff)) == total_ff) else $error("count mismatch");
`endif
endmodule
`default_nettype wire
